/* sv/opc_pkg.sv */
// package for the oxygen ppm compensation block
// types, widths, cubic coefficients and status codes; no dependencies
package opc_pkg;
   localparam int TempFracBits = 8;
   localparam logic signed [63:0] CoefA = 64'sd8633;
   localparam logic signed [63:0] CoefB = -64'sd111669;
   localparam logic signed [63:0] CoefC = 64'sd73014444;
   localparam logic signed [63:0] CoefD = 64'sd2409476653;

   localparam logic [1:0] CsrZeroRaw = 2'd0;
   localparam logic [1:0] CsrSpanRaw = 2'd1;
   localparam logic [1:0] CsrSpanPpm = 2'd2;
   localparam logic [1:0] CsrCalPres = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_SPAN = 2'd1,
      STATUS_ZERO_PRES = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [23:0] oxygen_raw;
      logic signed [15:0] temperature_q8;
      logic [23:0]        pressure_raw;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ppm_value;
      logic [1:0]         status_code;
      logic               saturated_flag;
   } rsp_type;

   typedef struct packed {
      logic [31:0] index;
      logic [31:0] data;
   } csr_type;

   // round half away from zero, right shift by the temperature fraction bits
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? (64'd0 - v) : v;
      m = (m + (64'd1 << (TempFracBits - 1))) >> TempFracBits;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction
endpackage

/* sv/opc_if.sv */
// valid/ready channel interfaces for the compensation block
// depends on opc_pkg
interface opc_req_if import opc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface opc_rsp_if import opc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface opc_csr_if import opc_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

/* sv/opc_divider.sv */
// pipelined restoring divider, one quotient bit per stage over a shift line
// depends on opc_pkg; stall is shared with the top level
module opc_divider import opc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  logic [127:0] in_num,
   input  logic [47:0]  in_den,
   input  logic         in_neg,
   input  rsp_type      in_meta,
   output logic         out_valid,
   output logic [63:0]  out_quot,
   output logic         out_neg,
   output rsp_type      out_meta
);
   localparam int Steps = 64;
   // low 64 quotient bits are needed; low 64 bits of numerator shifted in, one bit per stage
   logic [Steps:0]       v_ff;
   logic [48:0]          rem_ff  [Steps+1];
   logic [63:0]          low_ff  [Steps+1];
   logic [63:0]          quot_ff [Steps+1];
   logic [47:0]          den_ff  [Steps+1];
   logic                 neg_ff  [Steps+1];
   rsp_type              meta_ff [Steps+1];
   logic                 big;
   logic [48:0]          rem_in;
   rsp_type              meta_in;

   // quotient bits above 64 only flag overflow: high part >= den
   always_comb begin
      big    = (in_num[127:64] >= {16'd0, in_den});
      // remainder of high part modulo den when not big: high part < den fits 48 bits
      rem_in = {1'b0, in_num[111:64]};
      meta_in = in_meta;
      meta_in.saturated_flag = big;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (advance) v_ff[0] <= in_valid;
      if (advance) begin
         rem_ff[0]  <= rem_in;
         low_ff[0]  <= in_num[63:0];
         quot_ff[0] <= '0;
         den_ff[0]  <= in_den;
         neg_ff[0]  <= in_neg;
         meta_ff[0] <= meta_in;
      end
   end

   for (genvar g = 0; g < Steps; g++) begin : g_step
      logic [49:0] sh;
      logic        ge;
      always_comb begin
         sh = {rem_ff[g], low_ff[g][63]};
         ge = sh >= {2'd0, den_ff[g]};
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[g+1] <= 1'b0;
         else if (advance) v_ff[g+1] <= v_ff[g];
         if (advance) begin
            rem_ff[g+1]  <= ge ? 49'(sh - {2'd0, den_ff[g]}) : sh[48:0];
            low_ff[g+1]  <= {low_ff[g][62:0], 1'b0};
            quot_ff[g+1] <= {quot_ff[g][62:0], ge};
            den_ff[g+1]  <= den_ff[g];
            neg_ff[g+1]  <= neg_ff[g];
            meta_ff[g+1] <= meta_ff[g];
         end
      end
   end

   assign out_valid = v_ff[Steps];
   assign out_quot  = quot_ff[Steps];
   assign out_neg   = neg_ff[Steps];
   assign out_meta  = meta_ff[Steps];
endmodule

/* sv/oxygen_ppm_compensation.sv */
// top level: oxygen ppm compensation pipeline
// depends on opc_pkg, opc_if and opc_divider
//
// channel  dir  handshake     payload
// req      in   valid/ready   oxygen_raw, temperature_q8, pressure_raw
// rsp      out  valid/ready   ppm_value, status_code, saturated_flag
// csr      in   valid/ready   register index, write data
//
// one sample enters every cycle unless the result stalls; 74 register stages: cubic and products in
// eight stages, a divider input stage, one stage per quotient bit of the 64-stage
// divider, then the output register
// reset clears the valid line and loads the register reset values
// a stalled result holds the whole pipeline; the output register frees the input
module oxygen_ppm_compensation import opc_pkg::*; (
   input logic clock,
   input logic reset,
   opc_req_if.sink   req,
   opc_rsp_if.source rsp,
   opc_csr_if.sink   csr
);
   logic [23:0] zero_ff, span_ff, cal_ff;
   logic [19:0] ppm_ff;
   logic        advance;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= '0; span_ff <= 24'd1; ppm_ff <= '0; cal_ff <= 24'd1;
      end else if (csr.valid) begin
         if (csr.payload.index == 32'(CsrZeroRaw)) zero_ff <= csr.payload.data[23:0];
         if (csr.payload.index == 32'(CsrSpanRaw)) span_ff <= csr.payload.data[23:0];
         if (csr.payload.index == 32'(CsrSpanPpm)) ppm_ff  <= csr.payload.data[19:0];
         if (csr.payload.index == 32'(CsrCalPres)) cal_ff  <= csr.payload.data[23:0];
      end
   end

   // s1: capture, num/den, cubic step one
   logic [8:1]          v_ff;
   logic signed [15:0]  t_ff [1:2];
   logic signed [63:0]  k_ff [1:3];
   logic [23:0]         pres_ff [1:4];
   logic [24:0]         mnum_ff [1:2];
   logic                nnum_ff [1:2];
   logic                nden_ff [1:2];
   logic [23:0]         mden_ff [1:2];
   logic [1:0]          st_ff [1:8];
   logic [44:0]         np_ff [3:5];
   logic [47:0]         dn_ff [3:8];
   logic                neg_ff [3:8];
   logic [35:0]         mk_ff;
   logic [59:0]         pk_ff;
   logic [51:0]         pp_hh_ff, pp_hl_ff;
   logic [52:0]         pp_lh_ff, pp_ll_ff;
   logic [127:0]        sa_ff, sb_ff;
   logic [95:0]         nf_ff;

   logic signed [25:0]  num_c;
   logic signed [24:0]  den_c;
   logic [1:0]          st_c;
   logic signed [31:0]  p1_c;
   logic signed [47:0]  p2_c, p3_c;
   always_comb begin
      num_c = 26'(req.payload.oxygen_raw) - $signed({2'b0, zero_ff});
      den_c = $signed({1'b0, span_ff}) - $signed({1'b0, zero_ff});
      if (den_c == 0) st_c = STATUS_ZERO_SPAN;
      else if (cal_ff == 0) st_c = STATUS_ZERO_PRES;
      else st_c = STATUS_OK;
      p1_c = 16'(CoefA) * req.payload.temperature_q8;
      p2_c = $signed(k_ff[1][31:0]) * t_ff[1];
      p3_c = $signed(k_ff[2][31:0]) * t_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= {v_ff[7:1], req.valid};
      if (advance) begin
         t_ff[1]    <= req.payload.temperature_q8;
         k_ff[1]    <= round_shift(64'(p1_c)) + CoefB;
         pres_ff[1] <= req.payload.pressure_raw;
         mnum_ff[1] <= num_c[25] ? 25'(-num_c) : num_c[24:0];
         nnum_ff[1] <= num_c[25];
         nden_ff[1] <= den_c[24];
         mden_ff[1] <= den_c[24] ? 24'(-den_c) : den_c[23:0];
         st_ff[1]   <= st_c;
         // s2
         t_ff[2] <= t_ff[1]; k_ff[2] <= round_shift(64'(p2_c)) + CoefC;
         pres_ff[2] <= pres_ff[1]; mnum_ff[2] <= mnum_ff[1]; nnum_ff[2] <= nnum_ff[1];
         nden_ff[2] <= nden_ff[1]; mden_ff[2] <= mden_ff[1]; st_ff[2] <= st_ff[1];
         // s3: last cubic step, num * span ppm, denominator
         k_ff[3] <= round_shift(64'(p3_c)) + CoefD;
         pres_ff[3] <= pres_ff[2]; st_ff[3] <= st_ff[2];
         np_ff[3] <= 45'(mnum_ff[2]) * 45'(ppm_ff);
         neg_ff[3] <= nnum_ff[2] ^ nden_ff[2];
         dn_ff[3] <= 48'(mden_ff[2]) * 48'(cal_ff);
         // s4: magnitude of k
         mk_ff <= k_ff[3][63] ? 36'(-k_ff[3]) : k_ff[3][35:0];
         neg_ff[4] <= neg_ff[3] ^ k_ff[3][63];
         pres_ff[4] <= pres_ff[3]; np_ff[4] <= np_ff[3];
         st_ff[4] <= st_ff[3]; dn_ff[4] <= dn_ff[3];
         // s5: pressure * k
         pk_ff <= 60'(pres_ff[4]) * 60'(mk_ff);
         np_ff[5] <= np_ff[4]; neg_ff[5] <= neg_ff[4];
         st_ff[5] <= st_ff[4]; dn_ff[5] <= dn_ff[4];
         // s6: partial products
         pp_hh_ff <= 52'(np_ff[5][44:23]) * 52'(pk_ff[59:30]);
         pp_hl_ff <= 52'(np_ff[5][44:23]) * 52'(pk_ff[29:0]);
         pp_lh_ff <= 53'(np_ff[5][22:0]) * 53'(pk_ff[59:30]);
         pp_ll_ff <= 53'(np_ff[5][22:0]) * 53'(pk_ff[29:0]);
         neg_ff[6] <= neg_ff[5]; st_ff[6] <= st_ff[5]; dn_ff[6] <= dn_ff[5];
         // s7: partial sums plus rounding term
         sa_ff <= (128'(pp_hh_ff) << 53) + (128'(pp_lh_ff) << 30);
         sb_ff <= (128'(pp_hl_ff) << 23) + 128'(pp_ll_ff) + (128'(dn_ff[6]) << 31);
         neg_ff[7] <= neg_ff[6]; st_ff[7] <= st_ff[6]; dn_ff[7] <= dn_ff[6];
         // s8: full numerator scaled down by the k fraction bits
         nf_ff <= 96'((sa_ff + sb_ff) >> 32);
         neg_ff[8] <= neg_ff[7]; st_ff[8] <= st_ff[7]; dn_ff[8] <= dn_ff[7];
      end
   end

   rsp_type     meta_c, dmeta;
   logic        dvalid, dneg;
   logic [63:0] dquot;
   always_comb begin
      meta_c = '0;
      meta_c.status_code = st_ff[8];
   end

   opc_divider u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_ff[8]), .in_num({32'd0, nf_ff}),
      .in_den(dn_ff[8] == 0 ? 48'd1 : dn_ff[8]),
      .in_neg(neg_ff[8]), .in_meta(meta_c),
      .out_valid(dvalid), .out_quot(dquot), .out_neg(dneg), .out_meta(dmeta)
   );

   rsp_type res_c;
   always_comb begin
      logic [63:0] mag;
      logic        ovf;
      mag = dquot;
      ovf = dmeta.saturated_flag;
      res_c = '0;
      res_c.status_code = dmeta.status_code;
      if (dmeta.status_code == STATUS_OK) begin
         if (dneg) begin
            if (ovf || mag > 64'h8000_0000) begin
               res_c.ppm_value = 32'sh8000_0000; res_c.saturated_flag = 1'b1;
            end else res_c.ppm_value = 32'(64'd0 - mag);
         end else begin
            if (ovf || mag > 64'h7FFF_FFFF) begin
               res_c.ppm_value = 32'sh7FFF_FFFF; res_c.saturated_flag = 1'b1;
            end else res_c.ppm_value = mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= dvalid;
      if (advance) rsp_ff <= res_c;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.payload))
      else $error("result changed while stalled");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.status_code != STATUS_OK |->
      rsp.payload.ppm_value == 0 && !rsp.payload.saturated_flag)
      else $error("error result not cleared");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input blocked with empty output");
endmodule
